// ===== src/npec_pkg.sv =====
// ----------------------------------------------------------------------------
// npec_pkg
// Shared codes, widths and types for the NAND page ECC corrector.
// ----------------------------------------------------------------------------
package npec_pkg;

	// Fixed geometry of a sector and of the byte index field.
	localparam int SECTOR_BYTES = 512;
	localparam int BYTE_OFF_W   = 9;
	localparam int IDX_W        = 11;
	localparam int IDX_SPAN     = 2048;

	// Operation codes of an input transaction. The last code has no
	// operation behind it: it leaves the buffer and the tallies alone but still returns a result.
	localparam logic [1:0] OP_STORE  = 2'd0;
	localparam logic [1:0] OP_CHECK  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Sector verdict codes.
	localparam logic [1:0] VERDICT_CLEAN   = 2'd0;
	localparam logic [1:0] VERDICT_ECC_BIT = 2'd1;
	localparam logic [1:0] VERDICT_FIXED   = 2'd2;
	localparam logic [1:0] VERDICT_UNCORR  = 2'd3;

	// Page status codes.
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FIXED  = 2'd1;
	localparam logic [1:0] STATUS_UNCORR = 2'd2;

	// Saturation point of the page tallies.
	localparam logic [2:0] TALLY_MAX = 3'd7;

	// ECC word of an erased sector and the complement test pattern.
	localparam logic [31:0] ECC_BLANK = 32'hFFFF_FFFF;
	localparam logic [11:0] HALF_ONES = 12'hFFF;

	// Outcome of a syndrome decode.
	typedef struct packed {
		logic [1:0]            verdict;
		logic [BYTE_OFF_W-1:0] byte_off;
		logic [2:0]            bit_sel;
	} check_t;

endpackage

// ===== src/npec_in_if.sv =====
// ----------------------------------------------------------------------------
// npec_in_if
// Request channel: operation with its byte and ECC fields.
// ----------------------------------------------------------------------------
interface npec_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [10:0] byte_index;
	logic [7:0]  byte_value;
	logic [1:0]  sector;
	logic [31:0] ecc_stored;
	logic [31:0] ecc_computed;

	modport source (
		output valid, operation, byte_index, byte_value, sector, ecc_stored,
			ecc_computed,
		input  ready
	);

	modport sink (
		input  valid, operation, byte_index, byte_value, sector, ecc_stored,
			ecc_computed,
		output ready
	);
endinterface

// ===== src/npec_out_if.sv =====
// ----------------------------------------------------------------------------
// npec_out_if
// Result channel: read data, sector verdict and page tally.
// ----------------------------------------------------------------------------
interface npec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic [1:0] sector_verdict;
	logic [1:0] page_status;
	logic [2:0] corrected_count;
	logic [2:0] uncorrectable_count;

	modport source (
		output valid, data_out, sector_verdict, page_status, corrected_count,
			uncorrectable_count,
		input  ready
	);

	modport sink (
		input  valid, data_out, sector_verdict, page_status, corrected_count,
			uncorrectable_count,
		output ready
	);
endinterface

// ===== src/npec_syndrome.sv =====
// ----------------------------------------------------------------------------
// npec_syndrome
// Decodes a stored/computed ECC pair into a verdict and a bit position.
// ----------------------------------------------------------------------------
module npec_syndrome (
	input  logic [31:0]      ecc_stored,
	input  logic [31:0]      ecc_computed,
	output npec_pkg::check_t check
);

	logic [31:0] syn;
	logic [11:0] even_half;
	logic [11:0] odd_half;
	logic        single_bit;

	// Syndrome and its byte-swapped halves.
	assign syn        = ecc_stored ^ ecc_computed;
	assign even_half  = {syn[19:16], syn[31:24]};
	assign odd_half   = {syn[3:0], syn[15:8]};
	assign single_bit = ((syn & (syn - 32'd1)) == 32'd0);

	// Classify: blank or clean, ECC-word error, fixable data bit, or lost.
	always_comb begin
		check.byte_off = odd_half[11:3];
		check.bit_sel  = odd_half[2:0];
		if (ecc_stored == npec_pkg::ECC_BLANK || syn == 32'd0) begin
			check.verdict = npec_pkg::VERDICT_CLEAN;
		end else if (single_bit) begin
			check.verdict = npec_pkg::VERDICT_ECC_BIT;
		end else if ((even_half ^ odd_half) == npec_pkg::HALF_ONES) begin
			check.verdict = npec_pkg::VERDICT_FIXED;
		end else begin
			check.verdict = npec_pkg::VERDICT_UNCORR;
		end
	end

endmodule

// ===== src/npec_buffer.sv =====
// ----------------------------------------------------------------------------
// npec_buffer
// Page buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module npec_buffer #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/nand_page_ecc_corrector.sv =====
// An accepted transaction moves the block into the busy state; its result is
// loaded into the output register from there once that register is free.
// The block takes no new transaction until then: the busy state covers the
// page buffer's registered read and the write-back slot of a data-bit fix.
// A new transaction is taken while an earlier result waits on the output.
// Reset clears the tallies, the control state and the whole output register, not the page buffer.
// ----------------------------------------------------------------------------
// nand_page_ecc_corrector
// Page buffer with per-sector Hamming ECC check and single-bit data repair.
// ----------------------------------------------------------------------------
module nand_page_ecc_corrector #(
	parameter int SECTORS_PER_PAGE = 4
) (
	input logic         clk,
	input logic         arst_n,
	npec_in_if.sink     item,
	npec_out_if.source  result
);

	localparam int PAGE_BYTES = npec_pkg::SECTOR_BYTES * SECTORS_PER_PAGE;
	localparam int MEM_BYTES  =
		(PAGE_BYTES < npec_pkg::IDX_SPAN) ? PAGE_BYTES : npec_pkg::IDX_SPAN;
	localparam int MEM_AW     = $clog2(MEM_BYTES);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t                 state_q;
	logic                   acc;
	logic                   idx_ok;
	logic                   sec_ok;
	logic                   is_check;
	npec_pkg::check_t       check;
	logic [npec_pkg::IDX_W-1:0] fix_addr;
	logic [2:0]             corr_base;
	logic [2:0]             uncorr_base;
	logic [2:0]             corr_q;
	logic [2:0]             uncorr_q;
	logic                   rd_s1;
	logic                   fix_s1;
	logic [MEM_AW-1:0]      addr_s1;
	logic [2:0]             bit_s1;
	logic [1:0]             verdict_s1;
	logic                   out_free;
	logic                   mem_we;
	logic [MEM_AW-1:0]      mem_waddr;
	logic [7:0]             mem_wdata;
	logic                   mem_re;
	logic [MEM_AW-1:0]      mem_raddr;
	logic [7:0]             mem_rdata;

	function automatic logic [2:0] tally_bump(input logic [2:0] t);
		return (t == npec_pkg::TALLY_MAX) ? t : t + 3'd1;
	endfunction

	// Request handshake and range checks.
	assign item.ready = (state_q == ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign idx_ok     = (32'(item.byte_index) < PAGE_BYTES);
	assign sec_ok     = (32'(item.sector) < SECTORS_PER_PAGE);
	assign is_check   = (item.operation == npec_pkg::OP_CHECK) && sec_ok;
	assign out_free   = !result.valid || result.ready;

	npec_syndrome u_syndrome (
		.ecc_stored   (item.ecc_stored),
		.ecc_computed (item.ecc_computed),
		.check        (check)
	);

	// Byte that a data-bit fix lands on within the page.
	assign fix_addr = {item.sector, check.byte_off};

	// Buffer port control: stores and reads at accept, fix write-back in the first busy cycle.
	always_comb begin
		if (state_q == ST_BUSY) begin
			mem_we    = fix_s1;
			mem_waddr = addr_s1;
			mem_wdata = mem_rdata ^ 8'(8'd1 << bit_s1);
		end else begin
			mem_we    = acc && (item.operation == npec_pkg::OP_STORE) && idx_ok;
			mem_waddr = item.byte_index[MEM_AW-1:0];
			mem_wdata = item.byte_value;
		end
		if (item.operation == npec_pkg::OP_CHECK) begin
			mem_re    = acc && is_check && (check.verdict == npec_pkg::VERDICT_FIXED);
			mem_raddr = fix_addr[MEM_AW-1:0];
		end else begin
			mem_re    = acc && (item.operation == npec_pkg::OP_READ) && idx_ok;
			mem_raddr = item.byte_index[MEM_AW-1:0];
		end
	end

	npec_buffer #(
		.DEPTH (MEM_BYTES)
	) u_buffer (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Tally base: checking sector zero opens a new page.
	assign corr_base   = (item.sector == 2'd0) ? 3'd0 : corr_q;
	assign uncorr_base = (item.sector == 2'd0) ? 3'd0 : uncorr_q;

	// Sequencer, tallies and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                    <= ST_IDLE;
			corr_q                     <= 3'd0;
			uncorr_q                   <= 3'd0;
			rd_s1                      <= 1'b0;
			fix_s1                     <= 1'b0;
			addr_s1                    <= '0;
			bit_s1                     <= 3'd0;
			verdict_s1                 <= npec_pkg::VERDICT_CLEAN;
			result.valid               <= 1'b0;
			result.data_out            <= 8'd0;
			result.sector_verdict      <= npec_pkg::VERDICT_CLEAN;
			result.page_status         <= npec_pkg::STATUS_OK;
			result.corrected_count     <= 3'd0;
			result.uncorrectable_count <= 3'd0;
		end else begin
			// Drop a taken result unless a new one loads in the same cycle.
			if (result.valid && result.ready && !(state_q == ST_BUSY && out_free)) begin
				result.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q    <= ST_BUSY;
						rd_s1      <= (item.operation == npec_pkg::OP_READ) && idx_ok;
						fix_s1     <= is_check &&
							(check.verdict == npec_pkg::VERDICT_FIXED);
						addr_s1    <= fix_addr[MEM_AW-1:0];
						bit_s1     <= check.bit_sel;
						verdict_s1 <= is_check ? check.verdict : npec_pkg::VERDICT_CLEAN;
						if (is_check) begin
							if (check.verdict == npec_pkg::VERDICT_ECC_BIT ||
								check.verdict == npec_pkg::VERDICT_FIXED) begin
								corr_q   <= tally_bump(corr_base);
								uncorr_q <= uncorr_base;
							end else if (check.verdict == npec_pkg::VERDICT_UNCORR) begin
								corr_q   <= corr_base;
								uncorr_q <= tally_bump(uncorr_base);
							end else begin
								corr_q   <= corr_base;
								uncorr_q <= uncorr_base;
							end
						end
					end
				end
				ST_BUSY: begin
					// The fix write-back goes out on the first busy cycle only.
					fix_s1 <= 1'b0;
					if (out_free) begin
						state_q                    <= ST_IDLE;
						result.valid               <= 1'b1;
						result.data_out            <= rd_s1 ? mem_rdata : 8'd0;
						result.sector_verdict      <= verdict_s1;
						result.corrected_count     <= corr_q;
						result.uncorrectable_count <= uncorr_q;
						if (uncorr_q != 3'd0) begin
							result.page_status <= npec_pkg::STATUS_UNCORR;
						end else if (corr_q != 3'd0) begin
							result.page_status <= npec_pkg::STATUS_FIXED;
						end else begin
							result.page_status <= npec_pkg::STATUS_OK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// A fix write-back only follows directly on an accepted check.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY && fix_s1) |-> $past(acc && is_check))
		else $error("fix write-back without a preceding check");

	// Tallies move only on an accepted transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!acc) |-> ($stable(corr_q) && $stable(uncorr_q)))
		else $error("tally changed without a transaction");

	// A new result is loaded only out of the busy state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_BUSY))
		else $error("result raised outside the busy state");

	// Page status agrees with the reported uncorrectable count.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.page_status == npec_pkg::STATUS_UNCORR) ==
			(result.uncorrectable_count != 3'd0)))
		else $error("page status disagrees with uncorrectable count");
`endif

endmodule
